### sv/ssfa_pkg.sv
package ssfa_pkg;

  localparam int NFEAT         = 9;
  localparam int FEAT_W        = 32;
  localparam int SUM_W         = 64;
  localparam int CNT_W         = 32;
  localparam int LEN_W         = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int MAX_BLOCK_LEN_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOW       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_HIGH      = 2'd3;

  localparam logic signed [31:0] LEVEL_THRESHOLD_RST = -32'sd3276800;
  localparam logic [23:0] SILENCE_LIMIT_RST = 24'd22050;
  localparam logic [30:0] PITCH_LOW_RST     = 31'd3932160;
  localparam logic [30:0] PITCH_HIGH_RST    = 31'd39321600;

  typedef struct packed {
    logic [LEN_W-1:0] block_len;
    logic signed [FEAT_W-1:0] pitch;
    logic signed [FEAT_W-1:0] level_db;
    logic signed [FEAT_W-1:0] centroid;
    logic signed [FEAT_W-1:0] kurtosis;
    logic signed [FEAT_W-1:0] crossing_rate;
    logic signed [FEAT_W-1:0] crest;
    logic signed [FEAT_W-1:0] rolloff;
    logic signed [FEAT_W-1:0] peak_energy;
    logic signed [FEAT_W-1:0] flatness;
  } in_item_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] avg_pitch;
    logic signed [FEAT_W-1:0] avg_level_db;
    logic signed [FEAT_W-1:0] avg_centroid;
    logic signed [FEAT_W-1:0] avg_kurtosis;
    logic signed [FEAT_W-1:0] avg_crossing_rate;
    logic signed [FEAT_W-1:0] avg_crest;
    logic signed [FEAT_W-1:0] avg_rolloff;
    logic signed [FEAT_W-1:0] avg_peak_energy;
    logic signed [FEAT_W-1:0] avg_flatness;
    logic [CNT_W-1:0] segment_blocks;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_ACCUM,
    OP_FINISH
  } op_t;

  // classified command from front to back
  typedef struct packed {
    op_t op;
    logic loud;
    logic pitch_in_band;
    logic [LEN_W-1:0] len;
    logic signed [NFEAT*FEAT_W-1:0] feats;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_DIV,
    BK_OUT
  } bk_state_t;

endpackage

### sv/ssfa_if.sv
interface ssfa_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/ssfa_cfg_if.sv
interface ssfa_cfg_if
  import ssfa_pkg::*;
();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

### sv/ssfa_front.sv
module ssfa_front
  import ssfa_pkg::*;
#(
  parameter int MAX_BLOCK_LEN = MAX_BLOCK_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic signed [31:0] level_threshold,
  input  logic [23:0] silence_limit,
  input  logic [30:0] pitch_low,
  input  logic [30:0] pitch_high,
  output logic     q_valid,
  input  logic     q_ready,
  output cmd_t     q_data
);
  // front tracks segment and quiet state, back does sums and division
  localparam int QD = 2;

  logic in_seg_r, in_seg_nxt;
  logic [CNT_W-1:0] quiet_r, quiet_nxt;
  cmd_t q_mem_r [QD];
  logic [1:0] q_cnt_r;
  logic       q_wp_r, q_rp_r;

  logic acc, push, pop, loud, inband;
  logic [LEN_W-1:0] len;
  logic [CNT_W:0] qsum;
  logic [CNT_W-1:0] qbase;
  cmd_t cmd;

  assign in_ready = (q_cnt_r != 2'd2);
  assign acc = in_valid && in_ready;
  assign loud = $signed(in_data.level_db) >= level_threshold;
  assign inband = ($signed(in_data.pitch) >= $signed({1'b0, pitch_low})) &&
                  ($signed(in_data.pitch) <= $signed({1'b0, pitch_high}));
  assign len = (32'(in_data.block_len) > 32'(MAX_BLOCK_LEN)) ?
               LEN_W'(MAX_BLOCK_LEN) : in_data.block_len;
  assign qbase = loud ? '0 : quiet_r;
  assign qsum = {1'b0, qbase} + {{(CNT_W+1-LEN_W){1'b0}}, len};

  always_comb begin
    in_seg_nxt = in_seg_r;
    quiet_nxt = quiet_r;
    push = 1'b0;
    cmd.op = OP_ACCUM;
    cmd.loud = loud;
    cmd.pitch_in_band = inband;
    cmd.len = len;
    cmd.feats = {in_data.pitch, in_data.level_db, in_data.centroid, in_data.kurtosis,
                 in_data.crossing_rate, in_data.crest, in_data.rolloff,
                 in_data.peak_energy, in_data.flatness};
    if (acc) begin
      if (!in_seg_r) begin
        if (loud) begin
          in_seg_nxt = 1'b1;
          quiet_nxt = '0;
          cmd.op = OP_START;
          push = 1'b1;
        end
      end else if (quiet_r < {8'd0, silence_limit}) begin
        quiet_nxt = qsum[CNT_W] ? '1 : qsum[CNT_W-1:0];
        push = 1'b1;
      end else begin
        in_seg_nxt = 1'b0;
        cmd.op = OP_FINISH;
        push = 1'b1;
      end
    end
  end

  assign pop = q_valid && q_ready;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_data = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_seg_r <= 1'b0;
      quiet_r <= '0;
      q_cnt_r <= '0;
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
    end else begin
      in_seg_r <= in_seg_nxt;
      quiet_r <= quiet_nxt;
      if (push) q_wp_r <= ~q_wp_r;
      if (pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) q_mem_r[q_wp_r] <= cmd;
  end
endmodule

### sv/ssfa_divider.sv
module ssfa_divider
  import ssfa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic done,
  output logic signed [FEAT_W-1:0] quot
);
  // restoring division, one quotient bit a cycle, magnitude then sign
  logic [SUM_W-1:0] q_r, q_nxt;
  logic [CNT_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] d_r;
  logic             neg_r, busy_r;
  logic [6:0]       cnt_r;
  logic [CNT_W:0]   sh, diff;
  logic [SUM_W-1:0] mag;
  logic signed [SUM_W:0] sq;

  assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign sh = {rem_r[CNT_W-1:0], q_r[SUM_W-1]};
  assign diff = sh - {1'b0, d_r};
  assign rem_nxt = diff[CNT_W] ? sh : diff;
  assign q_nxt = {q_r[SUM_W-2:0], ~diff[CNT_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      q_r <= mag;
      rem_r <= '0;
      d_r <= (divisor == '0) ? CNT_W'(1) : divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sq = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  always_comb begin
    if (sq > $signed((SUM_W+1)'(32'h7FFFFFFF))) quot = 32'sh7FFFFFFF;
    else if (sq < -$signed((SUM_W+1)'(33'h080000000))) quot = 32'sh80000000;
    else quot = sq[FEAT_W-1:0];
  end
endmodule

### sv/ssfa_back.sv
module ssfa_back
  import ssfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  cmd_t      q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  bk_state_t st_r, st_nxt;
  logic signed [SUM_W-1:0] sum_r [NFEAT];
  logic [CNT_W-1:0] cnt_r;
  logic [3:0] idx_r, idx_nxt;
  logic signed [FEAT_W-1:0] avg_r [NFEAT];
  logic div_start, div_done, take;
  logic signed [FEAT_W-1:0] quot;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign take = q_valid && q_ready;

  ssfa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_r[idx_r]),
    .divisor(cnt_r), .done(div_done), .quot(quot)
  );

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    q_ready = 1'b0;
    div_start = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && q_data.op == OP_FINISH) begin
          st_nxt = BK_START;
          idx_nxt = '0;
        end
      end
      BK_START: begin
        div_start = 1'b1;
        st_nxt = BK_DIV;
      end
      BK_DIV: begin
        if (div_done) begin
          if (idx_r == 4'(NFEAT-1)) begin
            st_nxt = BK_OUT;
          end else begin
            idx_nxt = idx_r + 4'd1;
            st_nxt = BK_START;
          end
        end
      end
      BK_OUT: begin
        if (out_ready) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BK_IDLE;
    else st_r <= st_nxt;
  end

  // sums: start clears, accumulate saturates
  always_ff @(posedge clk) begin
    logic signed [SUM_W:0] s;
    logic signed [FEAT_W-1:0] f;
    idx_r <= idx_nxt;
    if (st_r == BK_DIV && div_done) avg_r[idx_r] <= quot;
    if (take) begin
      unique case (q_data.op)
        OP_START: begin
          cnt_r <= CNT_W'(1);
          for (int i = 0; i < NFEAT; i++) sum_r[i] <= '0;
        end
        OP_ACCUM: begin
          cnt_r <= cnt_inc;
          for (int i = 0; i < NFEAT; i++) begin
            f = q_data.feats[(NFEAT-1-i)*FEAT_W +: FEAT_W];
            s = {sum_r[i][SUM_W-1], sum_r[i]} + (SUM_W+1)'(f);
            if (i != 0 || q_data.pitch_in_band) begin
              if (s[SUM_W] != s[SUM_W-1])
                sum_r[i] <= s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
              else
                sum_r[i] <= s[SUM_W-1:0];
            end
          end
        end
        OP_FINISH: cnt_r <= cnt_inc;
        default: ;
      endcase
    end
  end

  assign out_valid = (st_r == BK_OUT);
  assign out_data = {avg_r[0], avg_r[1], avg_r[2], avg_r[3], avg_r[4], avg_r[5],
                     avg_r[6], avg_r[7], avg_r[8], cnt_r};
endmodule

### sv/sound_segment_feature_averager.sv
// sound segment feature averager
// in: one beat per audio block (length and nine q16.16 features)
// out: one beat per finished segment with nine averages and block count
// cfg: register writes (threshold, silence limit, pitch band), always ready
// the front classifies each block against the segment state and pushes a
// command into a two-entry queue unless the block is quiet outside a segment;
// it accepts a beat every cycle while the queue has room. the back sums each
// command as it takes it, and takes commands only while idle. at segment end
// it runs nine divisions, one after another, on one shared restoring divider.
// the result stays on out until taken; meanwhile the queue fills and in
// stalls once two more commands are queued.
// reset clears segment state and queue; registers return to defaults.
module sound_segment_feature_averager
  import ssfa_pkg::*;
#(
  parameter int MAX_BLOCK_LEN = MAX_BLOCK_LEN_DEF
) (
  input logic clk,
  input logic rst_n,
  ssfa_if.sink     in_ch,
  ssfa_if.source   out_ch,
  ssfa_cfg_if.sink cfg_ch
);
  logic signed [31:0] level_threshold_r;
  logic [23:0] silence_limit_r;
  logic [30:0] pitch_low_r, pitch_high_r;
  logic q_valid, q_ready;
  cmd_t q_data;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_threshold_r <= LEVEL_THRESHOLD_RST;
      silence_limit_r <= SILENCE_LIMIT_RST;
      pitch_low_r <= PITCH_LOW_RST;
      pitch_high_r <= PITCH_HIGH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_LEVEL_THRESHOLD: level_threshold_r <= cfg_ch.wdata;
        REG_SILENCE_LIMIT:   silence_limit_r <= cfg_ch.wdata[23:0];
        REG_PITCH_LOW:       pitch_low_r <= cfg_ch.wdata[30:0];
        REG_PITCH_HIGH:      pitch_high_r <= cfg_ch.wdata[30:0];
        default: ;
      endcase
    end
  end

  ssfa_front #(.MAX_BLOCK_LEN(MAX_BLOCK_LEN)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .level_threshold(level_threshold_r), .silence_limit(silence_limit_r),
    .pitch_low(pitch_low_r), .pitch_high(pitch_high_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  ssfa_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.segment_blocks != '0)
    else $error("segment count zero");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !q_ready)
    else $error("queue popped during output");
endmodule
